FILE: rtl/nhc_pkg.sv
// Shared types and constants for the noise hash counter generator.
// No dependencies; used by nhc_front, nhc_back and the top level.
`timescale 1ns / 1ps
package nhc_pkg;

  typedef enum logic [3:0] {
    REQ_RAW32     = 4'd0,
    REQ_LOW16     = 4'd1,
    REQ_BYTE      = 4'd2,
    REQ_BELOW     = 4'd3,
    REQ_INT_RANGE = 4'd4,
    REQ_UNIT      = 4'd5,
    REQ_FIX_RANGE = 4'd6,
    REQ_SUNIT     = 4'd7,
    REQ_CHANCE    = 4'd8,
    REQ_DIRECTION = 4'd9
  } req_t;

  localparam logic [3:0] REQ_LAST_CODE = 4'd9;

  localparam logic [0:0] CFG_SEED  = 1'b0;
  localparam logic [0:0] CFG_START = 1'b1;

  localparam logic [31:0] NOISE_A = 32'h68E31DA4;
  localparam logic [31:0] NOISE_B = 32'hB5297A4D;
  localparam logic [31:0] NOISE_C = 32'h1B56C4E9;
  localparam int          MIX_SHIFT = 8;

  // Classified request as it waits between front and back.
  typedef struct packed {
    req_t               op;
    logic [31:0]        divisor;
    logic [31:0]        range_low;
    logic signed [32:0] diff;
    logic [32:0]        probability;
  } item_t;

endpackage

FILE: rtl/nhc_front.sv
// Front end: accepts requests, drops unused codes, precomputes divisor and span,
// and holds them in a two-entry queue. Depends on nhc_pkg.
`timescale 1ns / 1ps
module nhc_front import nhc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  req_type,
  input  logic [31:0] bound,
  input  logic [31:0] range_low,
  input  logic [31:0] range_high,
  input  logic [32:0] probability,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  item_t       cls;
  logic        push;
  logic [31:0] span;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && (req_type <= REQ_LAST_CODE);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_comb begin
    span            = range_high - range_low + 32'd1;
    cls.op          = req_t'(req_type);
    cls.range_low   = range_low;
    cls.diff        = $signed({range_high[31], range_high}) - $signed({range_low[31], range_low});
    cls.probability = probability;
    cls.divisor     = (req_type == REQ_BELOW) ? bound : span;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/nhc_back.sv
// Back end: hash on a shared 33x33 multiplier, radix-2 remainder unit,
// result shaping and the output register. Depends on nhc_pkg.
`timescale 1ns / 1ps
module nhc_back import nhc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic        chance_hit,
  output logic        error,
  output logic        last
);

  localparam int NW = 33 + FRAC_BITS;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL1  = 10'b0000000010,
    S_MUL2  = 10'b0000000100,
    S_MUL3  = 10'b0000001000,
    S_FIN   = 10'b0000010000,
    S_POST  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_SCALE = 10'b0010000000,
    S_RANGE = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t               state;
  item_t                cur;
  logic                 second;
  logic [31:0]          seed;
  logic [31:0]          position;
  logic signed [65:0]   prod;
  logic [31:0]          h;
  logic [FRAC_BITS:0]   unit_q;
  logic [31:0]          rem;
  logic [4:0]           div_cnt;
  logic [31:0]          res_value;
  logic                 res_hit;
  logic                 res_err;
  logic                 res_last;

  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [65:0]   mul_p;
  logic [31:0]          t2;
  logic [31:0]          mix2;
  logic [31:0]          mix3;
  logic [31:0]          h_next;
  logic [NW-1:0]        num;
  logic [FRAC_BITS:0]   q0;
  logic [32:0]          r0;
  logic [FRAC_BITS:0]   unit_c;
  logic [31:0]          sunit;
  logic [32:0]          rem_sh;
  logic [32:0]          rem_sub;
  logic [31:0]          rem_new;
  logic signed [65:0]   rsum;
  logic signed [65:0]   roff;
  logic                 hit_c;
  logic                 out_free;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    t2     = prod[31:0] + seed;
    mix2   = t2 ^ (t2 >> MIX_SHIFT);
    mix3   = prod[31:0] ^ (prod[31:0] << MIX_SHIFT);
    h_next = prod[31:0] ^ (prod[31:0] >> MIX_SHIFT);
    case (state)
      S_MUL1: begin
        mul_a = $signed({1'b0, position});
        mul_b = $signed({1'b0, NOISE_A});
      end
      S_MUL2: begin
        mul_a = $signed({1'b0, mix2});
        mul_b = $signed({1'b0, NOISE_B});
      end
      S_MUL3: begin
        mul_a = $signed({1'b0, mix3});
        mul_b = $signed({1'b0, NOISE_C});
      end
      S_SCALE: begin
        mul_a = $signed(33'(unit_q));
        mul_b = cur.diff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // u = round(h * 2^F / (2^32 - 1)): quotient estimate from the top bits,
  // then a single correction since the residue stays below twice the divisor.
  always_comb begin
    num    = {1'b0, h, {FRAC_BITS{1'b0}}} + NW'(32'h7FFFFFFF);
    q0     = num[NW-1:32];
    r0     = {1'b0, num[31:0]} + 33'(q0);
    unit_c = q0 + ((r0 >= 33'h0FFFFFFFF) ? (FRAC_BITS+1)'(1) : (FRAC_BITS+1)'(0));
    sunit  = 32'({unit_c, 1'b0}) - (32'd1 << FRAC_BITS);
    hit_c  = cur.probability[32] || (h < cur.probability[31:0]) ||
             ((h == 32'd0) && (cur.probability[31:0] == 32'd0));
  end

  always_comb begin
    rem_sh  = {rem, h[~div_cnt]};
    rem_sub = rem_sh - {1'b0, cur.divisor};
    rem_new = rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];
    rsum    = prod + (66'sd1 <<< (FRAC_BITS - 1));
    roff    = rsum >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL1 || state == S_MUL2 || state == S_MUL3 || state == S_SCALE) begin
      prod <= mul_p;
    end
    if (q_pop) cur <= q_item;
    if (state == S_FIN) h <= h_next;
    if (state == S_POST) begin
      unit_q   <= unit_c;
      rem      <= 32'd0;
      div_cnt  <= 5'd0;
      res_hit  <= 1'b0;
      res_err  <= 1'b0;
      res_last <= !((cur.op == REQ_DIRECTION) && !second);
      case (cur.op)
        REQ_RAW32:     res_value <= h;
        REQ_LOW16:     res_value <= {16'd0, h[15:0]};
        REQ_BYTE:      res_value <= {24'd0, h[7:0]};
        REQ_BELOW: begin
          res_value <= 32'd0;
          res_err   <= (cur.divisor == 32'd0);
        end
        REQ_INT_RANGE: res_value <= h + cur.range_low;
        REQ_UNIT:      res_value <= 32'(unit_c);
        REQ_CHANCE: begin
          res_value <= 32'd0;
          res_hit   <= hit_c;
        end
        default:       res_value <= sunit;
      endcase
    end
    if (state == S_DIV) begin
      rem     <= rem_new;
      div_cnt <= div_cnt + 5'd1;
      if (div_cnt == 5'd31) begin
        res_value <= rem_new + ((cur.op == REQ_INT_RANGE) ? cur.range_low : 32'd0);
      end
    end
    if (state == S_RANGE) res_value <= cur.range_low + roff[31:0];
    if (state == S_EMIT && out_free) begin
      value      <= res_value;
      chance_hit <= res_hit;
      error      <= res_err;
      last       <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      second    <= 1'b0;
      seed      <= 32'd0;
      position  <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we && cfg_index == CFG_START) position <= cfg_data;
      else if (state == S_MUL1) position <= position + 32'd1;
      if (cfg_we && cfg_index == CFG_SEED) seed <= cfg_data;
      case (state)
        S_IDLE:  if (q_valid) state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_MUL3;
        S_MUL3:  state <= S_FIN;
        S_FIN:   state <= S_POST;
        S_POST: begin
          if ((cur.op == REQ_BELOW || cur.op == REQ_INT_RANGE) && cur.divisor != 32'd0) begin
            state <= S_DIV;
          end else if (cur.op == REQ_FIX_RANGE) begin
            state <= S_SCALE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_DIV:   if (div_cnt == 5'd31) state <= S_EMIT;
        S_SCALE: state <= S_RANGE;
        S_RANGE: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            if (cur.op == REQ_DIRECTION && !second) begin
              second <= 1'b1;
              state  <= S_MUL1;
            end else begin
              second <= 1'b0;
              state  <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < cur.divisor))
    else $error("remainder not below divisor");

  a_position_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL1 && !cfg_we) |=> (position == $past(position) + 32'd1))
    else $error("position did not advance by one");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_POST) |-> (unit_c <= ((FRAC_BITS+1)'(1) << FRAC_BITS)))
    else $error("unit fraction above one");

  a_error_only_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && res_err) |-> (cur.op == REQ_BELOW))
    else $error("error flag outside bounded mode");
`endif

endmodule

FILE: rtl/noise_hash_counter_rng_core.sv
// Top level of the noise hash counter generator: front queue plus back engine.
// Depends on nhc_pkg, nhc_front and nhc_back.
`timescale 1ns / 1ps
// Counter-based random generator: each request hashes the position counter with
// the seed in three multiply/xor-shift rounds on one shared multiplier, then the
// position advances. Bounded and integer-range modes with a nonzero divisor
// also pass through the bit-serial remainder unit, the fixed-point range mode
// adds a step for the scaling multiply, and the direction mode runs the hash
// twice and delivers two transactions. Unused request codes are dropped at the
// input with no result. A two-entry queue and the output register let requests
// be taken while a result waits on the output. Writing register 1 reloads the
// position counter; configure only while idle.
module noise_hash_counter_rng_core import nhc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  req_type,
  input  logic [31:0] bound,
  input  logic [31:0] range_low,
  input  logic [31:0] range_high,
  input  logic [32:0] probability,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic        chance_hit,
  output logic        error,
  output logic        last
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  nhc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .bound       (bound),
    .range_low   (range_low),
    .range_high  (range_high),
    .probability (probability),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  nhc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .chance_hit (chance_hit),
    .error      (error),
    .last       (last)
  );

endmodule
